@@ rtl/gop_window_cache_policy_core_defines.svh @@
// Assertion macros for the GOP window cache policy checker.
// No dependencies; included by files that assert.
`ifndef GOP_WINDOW_CACHE_POLICY_CORE_DEFINES_SVH
`define GOP_WINDOW_CACHE_POLICY_CORE_DEFINES_SVH

// Same-cycle implication, reset masked.
`define GWC_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, reset masked.
`define GWC_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

@@ rtl/gwc_pkg.sv @@
// Shared types and constants of the GOP window cache policy core.
// No dependencies.
package gwc_pkg;

	localparam int unsigned MaxGopsDefault = 16;
	localparam logic [15:0] FramesCap = 16'hFFFF;

	localparam logic [4:0]  RegCountReset = 5'd16;
	localparam logic [31:0] RegBytesReset = 32'd4194304;
	localparam logic [30:0] RegSpanReset  = 31'd0;

	typedef enum logic [1:0] {
		REG_MAX_GOP_COUNT   = 2'd0,
		REG_MAX_TOTAL_BYTES = 2'd1,
		REG_MAX_SPAN_MS     = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		CAUSE_NONE      = 3'd0,
		CAUSE_BAD_FRAME = 3'd1,
		CAUSE_DISABLED  = 3'd2,
		CAUSE_NO_GOP    = 3'd3,
		CAUSE_GOP_LIMIT = 3'd4
	} cause_t;

	typedef struct packed {
		logic        frame_valid;
		logic        is_video;
		logic        is_keyframe;
		logic [23:0] frame_size;
		logic signed [31:0] frame_time;
	} frame_in_t;

	typedef struct packed {
		logic        accepted;
		logic [2:0]  reject_cause;
		logic [4:0]  evicted_count;
		logic [4:0]  gop_count;
		logic [31:0] cached_bytes;
		logic [15:0] latest_frames;
		logic signed [31:0] latest_start;
		logic [31:0] latest_bytes;
	} result_out_t;

	// One GOP descriptor.
	typedef struct packed {
		logic signed [31:0] start_time;
		logic signed [31:0] end_time;
		logic [31:0] bytes;
		logic [15:0] frames;
	} gop_desc_t;

	// Command broadcast along the row of cells.
	typedef struct packed {
		logic        shift;
		logic        append;
		logic signed [31:0] frame_time;
		logic [23:0] frame_size;
	} cell_cmd_t;

endpackage

@@ rtl/gwc_cell.sv @@
// One GOP descriptor cell of the ring row.
// Depends on gwc_pkg.
module gwc_cell import gwc_pkg::*; (
	input  logic      clk,
	input  cell_cmd_t cmd,
	input  gop_desc_t prev,
	output gop_desc_t desc
);

	gop_desc_t desc_q;

	// Shift: take the neighbor's descriptor. Append: extend this GOP.
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			desc_q <= prev;
		end else if (cmd.append) begin
			desc_q.end_time <= cmd.frame_time;
			desc_q.bytes    <= desc_q.bytes + {8'd0, cmd.frame_size};
			if (desc_q.frames != FramesCap) begin
				desc_q.frames <= desc_q.frames + 16'd1;
			end
		end
	end

	assign desc = desc_q;

endmodule

@@ rtl/gop_window_cache_policy_core.sv @@
// Top level of the GOP window cache policy core.
// Depends on gwc_pkg and gwc_cell.
//
// Usage: one frame descriptor is transferred on in_valid/in_stall (in_data),
// one result per frame comes back on out_valid/out_stall (out_data).
// Configuration writes go through cfg_we/cfg_index/cfg_data while idle;
// new limits apply from the next accepted frame.
// GOP descriptors live in a row of KEPT_GOPS+1 cells, newest in cell 0.
// A keyframe shifts the whole row by one cell; eviction of the oldest GOP
// just shrinks the fill count, reading the oldest cell through one mux.
// Sequence: take the frame, evaluate and update, evict the oldest GOP one
// at a time until the limits are met, then register the result; a rejected
// frame goes straight from evaluation to the result register.
// A frame is taken only while the sequencer is idle; a finished result
// waits in the output register while the next frame is already taken.
// When the receiver stalls, out_data holds; a new result waits for it.
// Reset empties the cache (fill and byte total zero) and loads the
// default limits: 16 GOPs, 4194304 bytes, no span limit. Cell contents
// need no reset; only cells below the fill count are ever read.
module gop_window_cache_policy_core import gwc_pkg::*; #(
	parameter int unsigned KEPT_GOPS = MaxGopsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  frame_in_t   in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output result_out_t out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned Slots = KEPT_GOPS + 1;
	localparam int unsigned IW    = $clog2(Slots);
	localparam int unsigned FW    = $clog2(Slots + 1);
	localparam int unsigned LW    = FW + 6;

	typedef enum logic [1:0] {S_IDLE, S_EVAL, S_TRIM, S_DONE} state_t;

	state_t       state_q;
	logic [4:0]   max_count_q;
	logic [31:0]  max_bytes_q;
	logic [30:0]  max_span_q;
	frame_in_t    frame_q;
	logic [2:0]   cause_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] evict_q;
	logic [32:0]  bytes_q;
	logic         out_valid_q;
	result_out_t  out_q;

	gop_desc_t    cells [Slots];
	gop_desc_t    prevs [Slots];
	cell_cmd_t    cmd0;
	cell_cmd_t    cmd_rest;
	gop_desc_t    new_desc;
	gop_desc_t    newest;
	gop_desc_t    oldest;
	logic [IW-1:0] oldest_idx;
	logic [LW-1:0] count_lim;
	logic         is_bad;
	logic         is_disabled;
	logic         over_bytes_app;
	logic         over_span_app;
	logic         over;
	logic signed [32:0] span_app;
	logic signed [32:0] span_trim;
	logic         out_free;

	// Clamp the count register to KEPT_GOPS, the most GOPs kept.
	always_comb begin
		if ({{(LW-5){1'b0}}, max_count_q} > LW'(KEPT_GOPS)) begin
			count_lim = LW'(KEPT_GOPS);
		end else begin
			count_lim = {{(LW-5){1'b0}}, max_count_q};
		end
	end

	// Newest GOP sits in cell 0; the oldest sits at fill - 1.
	assign newest     = cells[0];
	assign oldest_idx = IW'(fill_q - FW'(1));
	assign oldest     = cells[oldest_idx];

	assign new_desc.start_time = frame_q.frame_time;
	assign new_desc.end_time   = frame_q.frame_time;
	assign new_desc.bytes      = {8'd0, frame_q.frame_size};
	assign new_desc.frames     = 16'd1;

	assign is_bad = !frame_q.frame_valid || !frame_q.is_video ||
		(frame_q.frame_size == 24'd0);
	assign is_disabled = (count_lim == '0) || (max_bytes_q == 32'd0) ||
		({8'd0, frame_q.frame_size} > max_bytes_q);

	// Append checks against the newest GOP.
	assign span_app = $signed({frame_q.frame_time[31], frame_q.frame_time}) -
		$signed({newest.start_time[31], newest.start_time});
	assign over_bytes_app = newest.bytes > (max_bytes_q - {8'd0, frame_q.frame_size});
	assign over_span_app  = (max_span_q != 31'd0) &&
		(span_app > $signed({2'b00, max_span_q}));

	// Trim check: count, byte budget, span from oldest start to newest end.
	assign span_trim = $signed({newest.end_time[31], newest.end_time}) -
		$signed({oldest.start_time[31], oldest.start_time});
	assign over = ({{(LW-FW){1'b0}}, fill_q} > count_lim) ||
		(bytes_q > {1'b0, max_bytes_q}) ||
		((fill_q > FW'(1)) && (max_span_q != 31'd0) &&
		 (span_trim > $signed({2'b00, max_span_q})));

	// Row commands: a keyframe shifts every cell, an append touches cell 0.
	always_comb begin
		cmd0 = '0;
		cmd0.frame_time = frame_q.frame_time;
		cmd0.frame_size = frame_q.frame_size;
		if (state_q == S_EVAL && !is_bad && !is_disabled) begin
			if (frame_q.is_keyframe) begin
				cmd0.shift = 1'b1;
			end else if (fill_q != '0 && !over_bytes_app && !over_span_app) begin
				cmd0.append = 1'b1;
			end
		end
		cmd_rest = cmd0;
		cmd_rest.append = 1'b0;
	end

	genvar gi;
	generate
		for (gi = 0; gi < Slots; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign prevs[gi] = new_desc;
				gwc_cell u_cell (.clk(clk), .cmd(cmd0), .prev(prevs[gi]), .desc(cells[gi]));
			end else begin : g_body
				assign prevs[gi] = cells[gi-1];
				gwc_cell u_cell (.clk(clk), .cmd(cmd_rest), .prev(prevs[gi]),
					.desc(cells[gi]));
			end
		end
	endgenerate

	assign out_free = !out_valid_q || !out_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= RegCountReset;
			max_bytes_q <= RegBytesReset;
			max_span_q  <= RegSpanReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_GOP_COUNT:   max_count_q <= cfg_data[4:0];
				REG_MAX_TOTAL_BYTES: max_bytes_q <= cfg_data;
				REG_MAX_SPAN_MS:     max_span_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Sequencer: take, evaluate, evict one GOP a cycle, hand off the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			bytes_q     <= '0;
			evict_q     <= '0;
			cause_q     <= CAUSE_NONE;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid on a new result, drop it once the result is taken.
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					evict_q <= '0;
					if (is_bad) begin
						cause_q <= CAUSE_BAD_FRAME;
						state_q <= S_DONE;
					end else if (is_disabled) begin
						cause_q <= CAUSE_DISABLED;
						state_q <= S_DONE;
					end else if (frame_q.is_keyframe) begin
						cause_q <= CAUSE_NONE;
						fill_q  <= fill_q + FW'(1);
						bytes_q <= bytes_q + {9'd0, frame_q.frame_size};
						state_q <= S_TRIM;
					end else if (fill_q == '0) begin
						cause_q <= CAUSE_NO_GOP;
						state_q <= S_DONE;
					end else if (over_bytes_app || over_span_app) begin
						cause_q <= CAUSE_GOP_LIMIT;
						state_q <= S_DONE;
					end else begin
						cause_q <= CAUSE_NONE;
						bytes_q <= bytes_q + {9'd0, frame_q.frame_size};
						state_q <= S_TRIM;
					end
				end
				S_TRIM: begin
					if (fill_q != '0 && over) begin
						fill_q  <= fill_q - FW'(1);
						bytes_q <= bytes_q - {1'b0, oldest.bytes};
						evict_q <= evict_q + FW'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Frame and result payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			frame_q <= in_data;
		end
		if (state_q == S_DONE && out_free) begin
			out_q.accepted      <= (cause_q == CAUSE_NONE);
			out_q.reject_cause  <= cause_q;
			out_q.evicted_count <= 5'(evict_q);
			out_q.gop_count     <= 5'(fill_q);
			out_q.cached_bytes  <= bytes_q[31:0];
			if (fill_q != '0) begin
				out_q.latest_frames <= newest.frames;
				out_q.latest_start  <= newest.start_time;
				out_q.latest_bytes  <= newest.bytes;
			end else begin
				out_q.latest_frames <= 16'd0;
				out_q.latest_start  <= 32'sd0;
				out_q.latest_bytes  <= 32'd0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/gwc_checker.sv @@
// Port-level checker for the GOP window cache policy core, with its bind.
// Depends on gwc_pkg and gop_window_cache_policy_core_defines.svh.
`include "gop_window_cache_policy_core_defines.svh"

module gwc_checker import gwc_pkg::*; #(
	parameter int unsigned KEPT_GOPS = MaxGopsDefault
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input result_out_t out_data
);

	`GWC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data), "stalled result changed")
	`GWC_ASSERT_NOW(a_accept_cause, clk, arst_n, out_valid,
		out_data.accepted == (out_data.reject_cause == CAUSE_NONE),
		"accepted flag disagrees with cause")
	`GWC_ASSERT_NOW(a_reject_no_evict, clk, arst_n, out_valid && !out_data.accepted,
		out_data.evicted_count == 5'd0, "rejected frame evicted GOPs")
	`GWC_ASSERT_NOW(a_empty_latest, clk, arst_n, out_valid && out_data.gop_count == 5'd0,
		out_data.latest_frames == 16'd0 && out_data.cached_bytes == 32'd0,
		"empty cache reports a GOP")
	`GWC_ASSERT_NOW(a_count_bound, clk, arst_n, out_valid,
		32'(out_data.gop_count) <= 32'(KEPT_GOPS), "GOP count beyond ring size")

endmodule

bind gop_window_cache_policy_core gwc_checker #(.KEPT_GOPS(KEPT_GOPS)) u_gwc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);
